### hw/rtl/rhss_pkg.sv
// Shared types and constants of the rolling hash string search block.
// Holds the channel payload structs, sequencer enums and hash arithmetic constants.
// No dependencies.
`default_nettype none

package rhss_pkg;

  // Field widths
  localparam int BYTE_W        = 8;
  localparam int POSITION_W    = 32;
  localparam int LENGTH_W      = 6;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 3;
  localparam int PATTERN_WORDS = 4;
  localparam int PAT_IDX_W     = 5;

  // Hash arithmetic: base 52 modulo 65713
  localparam int HASH_W        = 17;
  localparam int HASH_MOD_INT  = 65713;
  // Unreduced sum a*52 + b + 256*M - c*d stays below 2^25
  localparam int SUM_W         = 25;
  localparam int QUOT_W        = 9;
  localparam int QPROD_W       = SUM_W + QUOT_W;
  localparam int REM_W         = 18;

  localparam logic [HASH_W-1:0] HASH_BASE   = HASH_W'(52);
  localparam logic [HASH_W-1:0] HASH_MOD    = HASH_W'(HASH_MOD_INT);
  localparam logic [SUM_W-1:0]  HASH_OFFSET = SUM_W'(256 * HASH_MOD_INT);
  // Reciprocal of the modulus scaled by 2^SUM_W, rounded down
  localparam logic [QUOT_W-1:0] HASH_RECIP  = QUOT_W'((1 << SUM_W) / HASH_MOD_INT);

  localparam logic [POSITION_W-1:0] POSITION_MAX = '1;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_0 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_1 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_2 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_3 = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
  } text_item_t;

  typedef struct packed {
    logic                  found;
    logic [POSITION_W-1:0] match_position;
  } match_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_QUOT,
    S_SUB,
    S_FIX,
    S_VERIFY,
    S_EMIT
  } state_t;

  // What the shared multiply-reduce unit is working on
  typedef enum logic [1:0] {
    JOB_POWER,
    JOB_PATTERN,
    JOB_WINDOW
  } job_t;

endpackage

`default_nettype wire

### hw/rtl/rhss_stream_if.sv
// Valid/ready stream channel used for text input and match results.
// The payload type is set per instance; no other dependencies.
`default_nettype none

interface rhss_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hw/rtl/rolling_hash_string_search.sv
// Top level of the rolling hash string search block.
// Depends on rhss_pkg and the rhss_stream_if channel interface.
`default_nettype none

// Streams text bytes on the text channel and returns one result per text on the
// result channel: found with the zero-based start of the first match, or not found
// (position 0) after the byte marked end_of_text. Once a match is reported, the rest
// of that text is consumed silently. Program pattern_length and the pattern words
// between texts; the length and pattern hash are latched at the first byte of a text.
// Steps: each text byte goes through the single shared multiply-reduce unit: the
// product (on the transfer cycle, for a byte after the first), then reciprocal
// quotient, remainder, and correction. A byte that arrives after a match skips the
// unit and is closed on its transfer cycle. The first byte of a text first uses that
// same unit to form 52^L and then the pattern hash (L being the latched length), one
// pattern position at a time, and then takes its own rolling step. A hash hit adds a
// byte-by-byte compare, and a result is handed to the output register (waiting while
// that register still holds an earlier result), then held while more bytes are taken.
module rolling_hash_string_search
  import rhss_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write_enable,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  rhss_stream_if.sink                 text,
  rhss_stream_if.source               result
);

  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  // Configuration
  logic [LENGTH_W-1:0]   pattern_length;
  logic [CFG_DATA_W-1:0] pattern_word [PATTERN_WORDS];

  // Search state
  state_t                state, state_next;
  job_t                  job;
  logic [BYTE_W-1:0]     window [MAX_PATTERN_BYTES];
  logic [HASH_W-1:0]     window_hash;
  logic [HASH_W-1:0]     pattern_hash;
  logic [HASH_W-1:0]     base_power;
  logic [LEN_W-1:0]      active_length;
  logic [POSITION_W-1:0] bytes_seen;
  logic                  match_reported;
  logic [IDX_W-1:0]      idx;

  // Item and unit registers
  logic [BYTE_W-1:0]     item_byte;
  logic                  item_last;
  logic [SUM_W-1:0]      sum_reg;
  logic [QUOT_W-1:0]     quot_reg;
  logic [REM_W-1:0]      rem_reg;

  // Result registers
  logic                  pend_found;
  logic [POSITION_W-1:0] pend_pos;
  logic                  res_valid;
  logic                  res_found;
  logic [POSITION_W-1:0] res_pos;

  // Control strobes
  logic text_ready;
  logic mul_en;
  logic finish_en;
  logic finish_hit;
  logic finish_emit;
  logic emit_load;

  // Helpers
  logic                  text_xfer;
  logic                  bytes_zero;
  logic                  out_free;
  logic [LENGTH_W-1:0]   clamped_length;
  logic [LEN_W-1:0]      len_m1;
  logic [IDX_W-1:0]      len_m1_idx;
  logic                  idx_last;
  logic [IDX_W-1:0]      win_rd_idx;
  logic [BYTE_W-1:0]     win_rd_byte;
  logic [PAT_IDX_W-1:0]  pat_idx;
  logic [BYTE_W-1:0]     pat_byte;
  logic                  verify_eq;
  logic [BYTE_W-1:0]     cur_byte;
  logic                  cur_last;
  job_t                  job_sel;
  logic [HASH_W-1:0]     mul_a;
  logic [BYTE_W-1:0]     mul_b;
  logic [BYTE_W-1:0]     mul_c;
  logic [SUM_W-1:0]      scaled_a;
  logic [SUM_W-1:0]      drop_term;
  logic [SUM_W-1:0]      unit_sum;
  logic [QPROD_W-1:0]    quot_prod;
  logic [SUM_W-1:0]      quot_mod;
  logic [SUM_W-1:0]      rem_full;
  logic [REM_W-1:0]      rem_fixed;
  logic [HASH_W-1:0]     reduced;
  logic [POSITION_W-1:0] prior_p1;
  logic                  candidate;
  logic [POSITION_W-1:0] hit_pos;

  assign text_xfer  = text.valid && text_ready;
  assign bytes_zero = (bytes_seen == '0);
  assign out_free   = !res_valid || result.ready;

  // Clamp the programmed length to 1..MAX_PATTERN_BYTES
  always_comb begin
    if (pattern_length == '0) begin
      clamped_length = LENGTH_W'(1);
    end else if (pattern_length > LENGTH_W'(MAX_PATTERN_BYTES)) begin
      clamped_length = LENGTH_W'(MAX_PATTERN_BYTES);
    end else begin
      clamped_length = pattern_length;
    end
  end

  assign len_m1     = active_length - LEN_W'(1);
  assign len_m1_idx = len_m1[IDX_W-1:0];
  assign idx_last   = (idx == len_m1_idx);

  // Single window tap: oldest byte when rolling, pattern-aligned byte when verifying
  assign win_rd_idx  = (state == S_VERIFY) ? (len_m1_idx - idx) : len_m1_idx;
  assign win_rd_byte = window[win_rd_idx];

  // Pattern byte selected by the shared index
  assign pat_idx   = PAT_IDX_W'(idx);
  assign pat_byte  = pattern_word[pat_idx[4:3]][{pat_idx[2:0], 3'b000} +: BYTE_W];
  assign verify_eq = (win_rd_byte == pat_byte);

  // Byte under work: straight from the channel on the transfer cycle
  assign cur_byte = (state == S_IDLE) ? text.payload.text_byte : item_byte;
  assign cur_last = (state == S_IDLE) ? text.payload.end_of_text : item_last;
  assign job_sel  = (state == S_IDLE) ? JOB_WINDOW : job;

  // Operand selection for the shared unit
  always_comb begin
    mul_a = base_power;
    mul_b = '0;
    mul_c = '0;
    unique case (job_sel)
      JOB_POWER: begin
        mul_a = base_power;
      end
      JOB_PATTERN: begin
        mul_a = pattern_hash;
        mul_b = pat_byte;
      end
      JOB_WINDOW: begin
        mul_a = window_hash;
        mul_b = cur_byte;
        mul_c = win_rd_byte;
      end
      default: begin
        mul_a = base_power;
      end
    endcase
  end

  // Shared unit, product step: a*52 + b + 256*M - c*52^L, never negative
  assign scaled_a  = SUM_W'(mul_a) * SUM_W'(HASH_BASE);
  assign drop_term = SUM_W'(mul_c) * SUM_W'(base_power);
  assign unit_sum  = scaled_a + SUM_W'(mul_b) + HASH_OFFSET - drop_term;

  // Quotient estimate by reciprocal, at most one short
  assign quot_prod = QPROD_W'(sum_reg) * QPROD_W'(HASH_RECIP);

  // Remainder below twice the modulus, then one correction
  assign quot_mod  = SUM_W'(quot_reg) * SUM_W'(HASH_MOD);
  assign rem_full  = sum_reg - quot_mod;
  assign rem_fixed = (rem_reg >= REM_W'(HASH_MOD)) ? (rem_reg - REM_W'(HASH_MOD)) : rem_reg;
  assign reduced   = rem_fixed[HASH_W-1:0];

  // Match candidate once a full window is in; the byte count saturates at its 32-bit maximum
  assign prior_p1  = bytes_seen + POSITION_W'(1);
  assign candidate = (prior_p1 >= POSITION_W'(active_length)) && (reduced == pattern_hash);
  assign hit_pos   = (bytes_seen == POSITION_MAX) ? POSITION_MAX
                                                  : (prior_p1 - POSITION_W'(active_length));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (text.valid) begin
          if (bytes_zero) begin
            state_next = S_MUL;
          end else if (match_reported) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_QUOT;
          end
        end
      end
      S_MUL:  state_next = S_QUOT;
      S_QUOT: state_next = S_SUB;
      S_SUB:  state_next = S_FIX;
      S_FIX: begin
        if (job != JOB_WINDOW) begin
          state_next = S_MUL;
        end else if (candidate) begin
          state_next = S_VERIFY;
        end else if (item_last) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_VERIFY: begin
        if (verify_eq && idx_last) begin
          state_next = S_EMIT;
        end else if (!verify_eq) begin
          state_next = item_last ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    text_ready = 1'b0;
    mul_en     = 1'b0;
    finish_en  = 1'b0;
    finish_hit = 1'b0;
    emit_load  = 1'b0;
    unique case (state)
      S_IDLE: begin
        text_ready = 1'b1;
        if (text.valid && !bytes_zero) begin
          mul_en    = !match_reported;
          finish_en = match_reported;
        end
      end
      S_MUL: begin
        mul_en = 1'b1;
      end
      S_FIX: begin
        finish_en = (job == JOB_WINDOW) && !candidate;
      end
      S_VERIFY: begin
        finish_en  = !verify_eq || idx_last;
        finish_hit = verify_eq && idx_last;
      end
      S_EMIT: begin
        emit_load = out_free;
      end
      default: begin
        text_ready = 1'b0;
      end
    endcase
    finish_emit = finish_en && (finish_hit || (cur_last && !match_reported));
  end

  assign text.ready = text_ready;

  // Configuration, search state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      job            <= JOB_POWER;
      pattern_length <= LENGTH_W'(1);
      for (int w = 0; w < PATTERN_WORDS; w++) begin
        pattern_word[w] <= '0;
      end
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        window[k] <= '0;
      end
      window_hash    <= '0;
      pattern_hash   <= '0;
      base_power     <= '0;
      active_length  <= LEN_W'(1);
      bytes_seen     <= '0;
      match_reported <= 1'b0;
      idx            <= '0;
      res_valid      <= 1'b0;
    end else begin
      state <= state_next;

      // Register writes
      if (cfg_write_enable) begin
        unique case (cfg_index)
          REG_PATTERN_LENGTH: pattern_length  <= cfg_data[LENGTH_W-1:0];
          REG_PATTERN_WORD_0: pattern_word[0] <= cfg_data;
          REG_PATTERN_WORD_1: pattern_word[1] <= cfg_data;
          REG_PATTERN_WORD_2: pattern_word[2] <= cfg_data;
          REG_PATTERN_WORD_3: pattern_word[3] <= cfg_data;
          default: ;
        endcase
      end

      // Text start: latch the length, seed the power and pattern hash, clear the window hash
      if (text_xfer && bytes_zero) begin
        active_length <= LEN_W'(clamped_length);
        base_power    <= HASH_W'(1);
        pattern_hash  <= '0;
        window_hash   <= '0;
        job           <= JOB_POWER;
        idx           <= '0;
      end

      if (text_xfer && !bytes_zero && !match_reported) begin
        job <= JOB_WINDOW;
      end

      // Shift the new byte into the window as the rolling step starts
      if (mul_en && job_sel == JOB_WINDOW) begin
        window[0] <= cur_byte;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
          window[k] <= window[k-1];
        end
      end

      // Write back the reduced value and advance the sequencer
      if (state == S_FIX) begin
        unique case (job)
          JOB_POWER: begin
            base_power <= reduced;
            if (idx_last) begin
              job <= JOB_PATTERN;
              idx <= '0;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
          JOB_PATTERN: begin
            pattern_hash <= reduced;
            if (idx_last) begin
              job <= JOB_WINDOW;
              idx <= '0;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
          JOB_WINDOW: begin
            window_hash <= reduced;
            idx         <= '0;
          end
          default: ;
        endcase
      end

      if (state == S_VERIFY && verify_eq && !idx_last) begin
        idx <= idx + IDX_W'(1);
      end

      // Close the byte: drop the text state at its end, else count it and mark a match
      if (finish_en) begin
        if (cur_last) begin
          bytes_seen     <= '0;
          match_reported <= 1'b0;
          for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            window[k] <= '0;
          end
        end else begin
          if (bytes_seen != POSITION_MAX) begin
            bytes_seen <= prior_p1;
          end
          if (finish_hit) begin
            match_reported <= 1'b1;
          end
        end
      end

      // Output register: load a pending result, drop it once transferred
      if (emit_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (text_xfer) begin
      item_byte <= text.payload.text_byte;
      item_last <= text.payload.end_of_text;
    end
    if (mul_en) begin
      sum_reg <= unit_sum;
    end
    if (state == S_QUOT) begin
      quot_reg <= quot_prod[QPROD_W-1 -: QUOT_W];
    end
    if (state == S_SUB) begin
      rem_reg <= rem_full[REM_W-1:0];
    end
    if (finish_emit) begin
      pend_found <= finish_hit;
      pend_pos   <= finish_hit ? hit_pos : '0;
    end
    if (emit_load) begin
      res_found <= pend_found;
      res_pos   <= pend_pos;
    end
  end

  assign result.valid                  = res_valid;
  assign result.payload.found          = res_found;
  assign result.payload.match_position = res_pos;

endmodule

`default_nettype wire

### tb/tb_rolling_hash_string_search.sv
// Self-checking testbench of the rolling hash string search block.
// Holds a scoreboard class that predicts match results and the top module that drives it.
// Depends on rhss_pkg, rhss_stream_if and rolling_hash_string_search.
`timescale 1ns / 1ps

// Tracks the search state of the block and holds the match results it should produce
class match_tracker;
  logic [rhss_pkg::LENGTH_W-1:0]   length_reg;
  logic [rhss_pkg::CFG_DATA_W-1:0] pattern_reg [rhss_pkg::PATTERN_WORDS];
  logic [rhss_pkg::BYTE_W-1:0]     window [rhss_pkg::PATTERN_WORDS * 8];
  int unsigned                     window_hash;
  int unsigned                     pattern_hash;
  int unsigned                     leading_power;
  int unsigned                     active_length;
  logic [rhss_pkg::POSITION_W-1:0] bytes_seen;
  bit                              match_reported;
  rhss_pkg::match_item_t           expected_matches [$];
  int                              errors;
  int                              taken_bytes;
  int                              live_bytes;
  int                              results_seen;
  int                              matches_seen;

  function new();
    length_reg    = 1;
    foreach (pattern_reg[w]) pattern_reg[w] = '0;
    pattern_hash  = 0;
    leading_power = 0;
    active_length = 1;
    bytes_seen    = '0;
    errors        = 0;
    taken_bytes   = 0;
    live_bytes    = 0;
    results_seen  = 0;
    matches_seen  = 0;
    clear_window();
  endfunction

  function void clear_window();
    foreach (window[i]) window[i] = '0;
    window_hash    = 0;
    match_reported = 1'b0;
  endfunction

  function int pending();
    return expected_matches.size();
  endfunction

  function void write_reg(logic [rhss_pkg::CFG_INDEX_W-1:0] index,
                          logic [rhss_pkg::CFG_DATA_W-1:0] data);
    case (index)
      rhss_pkg::REG_PATTERN_LENGTH: length_reg     = data[rhss_pkg::LENGTH_W-1:0];
      rhss_pkg::REG_PATTERN_WORD_0: pattern_reg[0] = data;
      rhss_pkg::REG_PATTERN_WORD_1: pattern_reg[1] = data;
      rhss_pkg::REG_PATTERN_WORD_2: pattern_reg[2] = data;
      rhss_pkg::REG_PATTERN_WORD_3: pattern_reg[3] = data;
      default: ;
    endcase
  endfunction

  function logic [rhss_pkg::BYTE_W-1:0] pattern_at(int unsigned i);
    return pattern_reg[i / 8][(i % 8) * 8 +: 8];
  endfunction

  // Advance the search by one accepted text byte and queue any result it causes
  function void take_text_byte(rhss_pkg::text_item_t item);
    int unsigned           base;
    int unsigned           modulus;
    int unsigned           len;
    int unsigned           prior;
    int unsigned           old_term;
    int unsigned           pos;
    int unsigned           i;
    bit                    hit;
    bit                    same;
    rhss_pkg::match_item_t res;
    base    = int'(rhss_pkg::HASH_BASE);
    modulus = rhss_pkg::HASH_MOD_INT;
    hit     = 1'b0;
    pos     = 0;
    taken_bytes++;

    // Latch length, leading power and pattern hash at the first byte of a text
    if (bytes_seen == '0) begin
      if (length_reg == 0) active_length = 1;
      else if (length_reg > $size(window)) active_length = $size(window);
      else active_length = length_reg;
      leading_power = 1;
      for (i = 1; i < active_length; i++) leading_power = (leading_power * base) % modulus;
      pattern_hash = 0;
      for (i = 0; i < active_length; i++)
        pattern_hash = (pattern_hash * base + pattern_at(i)) % modulus;
      clear_window();
    end
    len   = active_length;
    prior = bytes_seen;

    // Roll the hash and shift the window; bytes after a match are dropped
    if (!match_reported) begin
      live_bytes++;
      if (prior >= len) begin
        old_term    = (window[len-1] * leading_power) % modulus;
        window_hash = (((window_hash + modulus - old_term) % modulus) * base
                       + item.text_byte) % modulus;
      end else begin
        window_hash = (window_hash * base + item.text_byte) % modulus;
      end
      for (i = $size(window) - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = item.text_byte;

      // A hash hit only counts when every byte agrees with the current pattern
      if (prior + 1 >= len && window_hash == pattern_hash) begin
        same = 1'b1;
        for (i = 0; i < len; i++) begin
          if (window[len-1-i] != pattern_at(i)) same = 1'b0;
        end
        if (same) begin
          hit            = 1'b1;
          match_reported = 1'b1;
          pos            = (prior == rhss_pkg::POSITION_MAX) ? rhss_pkg::POSITION_MAX
                                                             : prior + 1 - len;
        end
      end
    end

    if (bytes_seen != rhss_pkg::POSITION_MAX) bytes_seen++;

    if (hit) begin
      res.found          = 1'b1;
      res.match_position = pos;
      expected_matches.push_back(res);
    end
    // The end of a text reports not found unless a match has gone out already
    if (item.end_of_text) begin
      if (!match_reported) begin
        res.found          = 1'b0;
        res.match_position = '0;
        expected_matches.push_back(res);
      end
      bytes_seen = '0;
      clear_window();
    end
  endfunction

  // Compare one result transfer with the oldest queued result
  function void check_match(rhss_pkg::match_item_t got);
    rhss_pkg::match_item_t want;
    results_seen++;
    if (expected_matches.size() == 0) begin
      errors++;
      $display("%0t: result with none pending: found %0b position %0d",
               $time, got.found, got.match_position);
      return;
    end
    want = expected_matches.pop_front();
    if (want.found) matches_seen++;
    if (got.found !== want.found) begin
      errors++;
      $display("%0t: found mismatch: expected %0b, actual %0b", $time, want.found, got.found);
    end
    if (got.match_position !== want.match_position) begin
      errors++;
      $display("%0t: match_position mismatch: expected %0d, actual %0d",
               $time, want.match_position, got.match_position);
    end
  endfunction
endclass

module tb_rolling_hash_string_search;
  import rhss_pkg::*;

  localparam int ITEM_TARGET = 1850;
  localparam int MAX_GAP     = 16;
  // Worst byte: set-up of a full-length pattern, the byte itself, full compare, hand-over
  localparam int SETTLE_CYCLES = 8 * 32 + 4 + 32 + 1 + 40;
  localparam int HOLD_CYCLES   = 600;
  localparam int STALL_LIMIT   = 4000;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write_enable;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   no_idle = 1'b0;
  logic                   hold_off_request = 1'b0;
  int                     idle_cycles = 0;
  int                     settings_used = 0;
  match_tracker           tracker;

  rhss_stream_if #(.payload_t(text_item_t))  text_ch ();
  rhss_stream_if #(.payload_t(match_item_t)) result_ch ();

  rolling_hash_string_search #(.MAX_PATTERN_BYTES(32)) u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .text             (text_ch),
    .result           (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Offer a text byte by byte, optionally marking the last byte as end of text
  task automatic send_text(input logic [BYTE_W-1:0] bytes [$], input bit terminate);
    text_item_t item;
    int         gap;
    foreach (bytes[i]) begin
      gap = draw_gap();
      if (gap > 0) begin
        text_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      item.text_byte   = bytes[i];
      item.end_of_text = terminate && (i == bytes.size() - 1);
      text_ch.valid   <= 1'b1;
      text_ch.payload <= item;
      do @(posedge clk); while (!text_ch.ready);
    end
  endtask

  // Write the length register and all four pattern words
  task automatic program_search(input logic [CFG_DATA_W-1:0] length_data,
                                input logic [CFG_DATA_W-1:0] w0, w1, w2, w3);
    logic [CFG_DATA_W-1:0]  values  [5];
    logic [CFG_INDEX_W-1:0] indexes [5];
    values  = '{length_data, w0, w1, w2, w3};
    indexes = '{REG_PATTERN_LENGTH, REG_PATTERN_WORD_0, REG_PATTERN_WORD_1,
                REG_PATTERN_WORD_2, REG_PATTERN_WORD_3};
    foreach (values[r]) begin
      cfg_write_enable <= 1'b1;
      cfg_index        <= indexes[r];
      cfg_data         <= values[r];
      @(posedge clk);
    end
    cfg_write_enable <= 1'b0;
    settings_used++;
  endtask

  // Drop valid, wait for every queued result, then let the block settle
  task automatic wait_idle();
    text_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Monitor: check results before noting inputs so a same-edge pair stays ordered
  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) tracker.check_match(result_ch.payload);
      if (text_ch.valid && text_ch.ready) tracker.take_text_byte(text_ch.payload);
      if (cfg_write_enable) tracker.write_reg(cfg_index, cfg_data);
    end
  end

  // Watchdog on cycles without any transfer or register write
  always @(posedge clk) begin
    if (rst || cfg_write_enable || (text_ch.valid && text_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results pending",
               $time, idle_cycles, tracker.pending());
      $display("[rolling_hash_string_search] ERROR");
      $finish;
    end
  end

  // Result side: random stalls, and one long hold-off when asked for
  initial begin
    int hold;
    result_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = draw_gap();
      if (hold_off_request) begin
        hold_off_request <= 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        result_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  // Stimulus
  initial begin
    logic [BYTE_W-1:0]     text_q [$];
    logic [BYTE_W-1:0]     pat [32];
    logic [BYTE_W-1:0]     sym [2];
    logic [CFG_DATA_W-1:0] words [4];
    logic [CFG_DATA_W-1:0] length_data;
    int                    phase;
    int                    texts;
    int                    tlen;
    int                    eff;
    int                    spot;
    int                    pick;
    int                    len_value;
    bit                    alphabet;
    bit                    pressure;

    tracker          = new();
    rst              = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    text_ch.valid    = 1'b0;
    text_ch.payload  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one zero byte, matched on the final byte
    text_q = '{8'hFF, 8'h00};
    send_text(text_q, 1'b1);
    wait_idle();

    // Hash collision: 24,15,37 and 0,0,0 both hash to zero, so only the real bytes match
    program_search(64'd3, 64'h0000_0000_0025_0F18, '0, '0, '0);
    text_q = '{8'h00, 8'h00, 8'h00};
    send_text(text_q, 1'b1);
    text_q = '{8'd24, 8'd15, 8'd37};
    send_text(text_q, 1'b1);
    wait_idle();

    // Full-length pattern of 0xFF against a one-byte text
    program_search(64'd32, '1, '1, '1, '1);
    text_q = '{8'hFF};
    send_text(text_q, 1'b1);
    wait_idle();

    // Length zero acts as one; upper data bits ignored; bytes after the match dropped
    program_search(64'hFFFF_FFFF_FFFF_FFC0, 64'hAB, '0, '0, '0);
    text_q = '{8'h01, 8'hAB, 8'hAB, 8'h02};
    send_text(text_q, 1'b1);
    wait_idle();

    // Length above the maximum is clamped
    program_search(64'd63, '0, '0, '0, '0);
    text_q = '{8'h00};
    send_text(text_q, 1'b1);
    wait_idle();

    // Two-byte match at position zero ending on the final byte
    program_search(64'd2, 64'hFF00, '0, '0, '0);
    text_q = '{8'h00, 8'hFF};
    send_text(text_q, 1'b1);
    wait_idle();

    // Pattern rewritten mid-text: latched hash of AB no longer agrees with bytes CD
    program_search(64'd2, 64'h4241, '0, '0, '0);
    text_q = '{8'h78};
    send_text(text_q, 1'b0);
    wait_idle();
    program_search(64'd2, 64'h4443, '0, '0, '0);
    text_q = '{8'h41, 8'h42, 8'h43, 8'h44};
    send_text(text_q, 1'b1);
    wait_idle();

    // Random phases: new settings, a few texts, then drain
    phase = 0;
    while (tracker.taken_bytes < ITEM_TARGET) begin
      pressure = (phase == 3);
      pick     = $urandom_range(0, 99);
      if (pressure) len_value = $urandom_range(1, 4);
      else if (pick < 65) len_value = $urandom_range(1, 8);
      else if (pick < 80) len_value = $urandom_range(9, 31);
      else if (pick < 92) len_value = 32;
      else if (pick < 96) len_value = 0;
      else len_value = $urandom_range(33, 63);
      eff = (len_value == 0) ? 1 : (len_value > 32) ? 32 : len_value;

      // Small alphabets give overlapping near-matches
      alphabet = ($urandom_range(0, 2) == 0);
      sym[0]   = 8'($urandom_range(0, 255));
      sym[1]   = 8'($urandom_range(0, 255));
      for (int i = 0; i < 32; i++) begin
        pat[i] = alphabet ? sym[$urandom_range(0, 1)] : 8'($urandom_range(0, 255));
        words[i / 8][(i % 8) * 8 +: 8] = pat[i];
      end
      length_data = {$urandom, $urandom};
      length_data[LENGTH_W-1:0] = LENGTH_W'(len_value);
      program_search(length_data, words[0], words[1], words[2], words[3]);

      no_idle <= pressure || ($urandom_range(0, 3) == 0);
      if (pressure) hold_off_request <= 1'b1;
      texts = pressure ? 16 : $urandom_range(1, 5);

      repeat (texts) begin
        if (pressure) tlen = $urandom_range(1, 4);
        else if ($urandom_range(0, 9) < 7) tlen = $urandom_range(1, eff + 8);
        else tlen = $urandom_range(eff, 3 * eff + 16);
        text_q.delete();
        repeat (tlen) begin
          if (alphabet) text_q.push_back(sym[$urandom_range(0, 1)]);
          else if ($urandom_range(0, 3) == 0) text_q.push_back(pat[$urandom_range(0, eff - 1)]);
          else text_q.push_back(8'($urandom_range(0, 255)));
        end
        // Mostly embed the pattern; sometimes leave only its prefix at the end
        pick = $urandom_range(0, 9);
        if (pick < 6 && tlen >= eff) begin
          spot = $urandom_range(0, tlen - eff);
          for (int i = 0; i < eff; i++) text_q[spot + i] = pat[i];
        end else if (pick == 6 && eff > 1 && tlen >= eff - 1) begin
          spot = tlen - eff + 1;
          for (int i = 0; i < eff - 1; i++) text_q[spot + i] = pat[i];
        end
        send_text(text_q, 1'b1);
      end
      wait_idle();
      phase++;
    end

    $display("Fed %0d text bytes, %0d searched before a match, under %0d pattern settings",
             tracker.taken_bytes, tracker.live_bytes, settings_used);
    $display("Compared %0d results, %0d of them matches, with stalls on both channels",
             tracker.results_seen, tracker.matches_seen);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[rolling_hash_string_search] OK");
    end else begin
      $display("[rolling_hash_string_search] ERROR");
    end
    $finish;
  end
endmodule
